// ===== rtl/plvd_pkg.sv =====
package plvd_pkg;

   // Widths of the stream fields and the block count register.
   localparam int BYTE_WIDTH  = 8;
   localparam int VALUE_WIDTH = 64;
   localparam int COUNT_WIDTH = 17;
   localparam int CTR_WIDTH   = 16;
   localparam int LEFT_WIDTH  = 4;
   localparam int POS_WIDTH   = 3;
   localparam int HIGH_WIDTH  = 6;
   localparam int LANES       = VALUE_WIDTH / BYTE_WIDTH;

   // Header byte boundaries of the encoding.
   localparam logic [BYTE_WIDTH-1:0]  ONE_BYTE_LIMIT = 8'd185;
   localparam logic [BYTE_WIDTH-1:0]  TWO_BYTE_LIMIT = 8'd249;
   localparam logic [BYTE_WIDTH-1:0]  PAYLOAD_BIAS   = 8'd247;
   localparam logic [COUNT_WIDTH-1:0] MAX_BLOCK      = 17'd65536;

   // Parser modes.
   typedef enum logic [1:0] {
      MODE_HEADER  = 2'd0,
      MODE_SECOND  = 2'd1,
      MODE_PAYLOAD = 2'd2
   } mode_type;

endpackage

// ===== rtl/prefix_length_varint_decoder_top.sv =====
// Decodes a byte stream of length-prefixed little-endian integers. A header
// below 185 is the value itself, a header from 185 to 248 takes one more byte,
// and a header from 249 to 255 is followed by 2 to 8 payload bytes, least
// significant first. One byte item is taken per clock; the result item for a
// completed value appears in the cycle after its last byte is accepted, held in
// a single output register, and the input keeps flowing while that register
// is empty or being drained in the same cycle. The per-byte update of the
// parser state and the 64-bit byte-lane merge lie on the path into it.
// rsp_tuser flags the value that completes each block of csr_wr_data values
// (a count of zero acts as 1, a count above 65536 acts as 65536).
module prefix_length_varint_decoder_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [plvd_pkg::COUNT_WIDTH-1:0]    csr_wr_data,  // values_per_block
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [plvd_pkg::BYTE_WIDTH-1:0]     req_tdata,    // [7:0] data_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [plvd_pkg::VALUE_WIDTH-1:0]    rsp_tdata,    // [63:0] value
   output logic [0:0]                          rsp_tuser     // [0] end_of_block
);
   import plvd_pkg::*;

   logic [COUNT_WIDTH-1:0] block_count_ff;
   mode_type               mode_ff, mode_in;
   logic [LEFT_WIDTH-1:0]  left_ff, left_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [HIGH_WIDTH-1:0]  high_ff, high_in;
   logic [CTR_WIDTH-1:0]   counter_ff, counter_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   logic                   rsp_eob_ff;

   logic                   req_fire;
   logic                   emit;
   logic [VALUE_WIDTH-1:0] emit_value;
   logic [VALUE_WIDTH-1:0] merged;
   logic [COUNT_WIDTH-1:0] limit;
   logic [COUNT_WIDTH-1:0] done;
   logic                   last;

   // The output register accepts a new result when empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // Configuration register for the block length.
   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= COUNT_WIDTH'(1);
      end else if (csr_wr_en) begin
         block_count_ff <= csr_wr_data;
      end
   end

   // Clamp the block length into its legal range.
   always_comb begin
      if (block_count_ff == '0) begin
         limit = COUNT_WIDTH'(1);
      end else if (block_count_ff > MAX_BLOCK) begin
         limit = MAX_BLOCK;
      end else begin
         limit = block_count_ff;
      end
   end

   assign done = {1'b0, counter_ff} + COUNT_WIDTH'(1);
   assign last = done >= limit;

   // Drop the incoming byte into its lane of the accumulator.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         merged[i*BYTE_WIDTH +: BYTE_WIDTH] = acc_ff[i*BYTE_WIDTH +: BYTE_WIDTH] |
            ((pos_ff == POS_WIDTH'(i)) ? req_tdata : '0);
      end
   end

   // Parser next state and the completed value, if any.
   always_comb begin
      mode_in    = mode_ff;
      left_in    = left_ff;
      pos_in     = pos_ff;
      acc_in     = acc_ff;
      high_in    = high_ff;
      emit       = 1'b0;
      emit_value = '0;
      case (mode_ff)
         MODE_SECOND: begin
            mode_in    = MODE_HEADER;
            emit       = 1'b1;
            emit_value = VALUE_WIDTH'(ONE_BYTE_LIMIT) + VALUE_WIDTH'(req_tdata) +
                         VALUE_WIDTH'({high_ff, {BYTE_WIDTH{1'b0}}});
         end
         MODE_PAYLOAD: begin
            acc_in  = merged;
            pos_in  = pos_ff + POS_WIDTH'(1);
            left_in = left_ff - LEFT_WIDTH'(1);
            if (left_ff == LEFT_WIDTH'(1)) begin
               mode_in    = MODE_HEADER;
               emit       = 1'b1;
               emit_value = merged;
            end
         end
         default: begin
            // Header byte; the unused mode is treated the same way.
            mode_in = MODE_HEADER;
            if (req_tdata < ONE_BYTE_LIMIT) begin
               emit       = 1'b1;
               emit_value = VALUE_WIDTH'(req_tdata);
            end else if (req_tdata < TWO_BYTE_LIMIT) begin
               high_in = HIGH_WIDTH'(req_tdata - ONE_BYTE_LIMIT);
               mode_in = MODE_SECOND;
            end else begin
               left_in = LEFT_WIDTH'(req_tdata - PAYLOAD_BIAS);
               pos_in  = '0;
               acc_in  = '0;
               mode_in = MODE_PAYLOAD;
            end
         end
      endcase
   end

   // Block counter advances on every completed value.
   always_comb begin
      counter_in = counter_ff;
      if (req_fire && emit) begin
         counter_in = last ? '0 : done[CTR_WIDTH-1:0];
      end
   end

   // Output register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Parser state and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_HEADER;
         left_ff      <= '0;
         pos_ff       <= '0;
         high_ff      <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            mode_ff <= mode_in;
            left_ff <= left_in;
            pos_ff  <= pos_in;
            high_ff <= high_in;
         end
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: accumulator and the result item.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         acc_ff <= acc_in;
         if (emit) begin
            rsp_value_ff <= emit_value;
            rsp_eob_ff   <= last;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_value_ff;
   assign rsp_tuser[0] = rsp_eob_ff;

   // A long value never has more payload bytes pending than lanes left.
   a_payload_bounds: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_PAYLOAD |->
         left_ff != '0 && ({1'b0, pos_ff} + left_ff) <= LEFT_WIDTH'(LANES))
      else $error("payload byte count out of range");

   // A single-byte header yields a result in the next cycle.
   a_short_value: assert property (@(posedge clock) disable iff (reset)
      req_fire && mode_ff == MODE_HEADER && req_tdata < ONE_BYTE_LIMIT |=>
         rsp_tvalid && rsp_tdata == VALUE_WIDTH'($past(req_tdata)))
      else $error("single-byte value not delivered");

   // A two-byte value lies between 185 and 16568.
   a_two_byte_range: assert property (@(posedge clock) disable iff (reset)
      req_fire && mode_ff == MODE_SECOND |=>
         rsp_tvalid && rsp_tdata >= VALUE_WIDTH'(ONE_BYTE_LIMIT) &&
         rsp_tdata[VALUE_WIDTH-1:15] == '0)
      else $error("two-byte value out of range");

   // The last payload byte completes the value and returns to header mode.
   a_payload_done: assert property (@(posedge clock) disable iff (reset)
      req_fire && mode_ff == MODE_PAYLOAD && left_ff == LEFT_WIDTH'(1) |=>
         rsp_tvalid && mode_ff == MODE_HEADER)
      else $error("long value not completed");

endmodule
